// File: rtl/tbgm_pkg.sv
package tbgm_pkg;

   localparam int OPCODE_W = 8;
   localparam int AMOUNT_W = 32;

   // Operation codes as they arrive on the request word.
   localparam logic [2:0] OPC_LOAD   = 3'd0;
   localparam logic [2:0] OPC_START  = 3'd1;
   localparam logic [2:0] OPC_ENTER  = 3'd2;
   localparam logic [2:0] OPC_CHARGE = 3'd3;
   localparam logic [2:0] OPC_RETURN = 3'd4;
   localparam logic [2:0] OPC_HALT   = 3'd5;

   typedef struct packed {
      logic [2:0]          operation;
      logic [OPCODE_W-1:0] opcode;
      logic [AMOUNT_W-1:0] dyn_multiplier;
      logic [AMOUNT_W-1:0] l2_amount;
      logic [AMOUNT_W-1:0] da_amount;
      logic [AMOUNT_W-1:0] l2_extra;
      logic [AMOUNT_W-1:0] da_extra;
      logic                exceptional;
      logic                call_mark;
   } req_word_type;

   typedef struct packed {
      logic                gas_exhausted;
      logic [AMOUNT_W-1:0] l2_left;
      logic [AMOUNT_W-1:0] da_left;
      logic [AMOUNT_W-1:0] reported_l2_left;
      logic [AMOUNT_W-1:0] reported_da_left;
      logic                row_tag;
      logic [OPCODE_W-1:0] row_opcode;
      logic [AMOUNT_W-1:0] opcode_use_total;
   } rsp_word_type;

   // Decoded command class; unused operation codes become a no-op.
   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_START,
      KIND_ENTER,
      KIND_CHARGE,
      KIND_RETURN,
      KIND_HALT,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic                in_range;
      logic [OPCODE_W-1:0] opcode;
      logic [AMOUNT_W-1:0] mult;
      logic [AMOUNT_W-1:0] amt_l2;
      logic [AMOUNT_W-1:0] amt_da;
      logic [AMOUNT_W-1:0] ext_l2;
      logic [AMOUNT_W-1:0] ext_da;
      logic                exceptional;
      logic                call_mark;
   } cmd_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0] base_l2;
      logic [AMOUNT_W-1:0] base_da;
      logic [AMOUNT_W-1:0] dyn_l2;
      logic [AMOUNT_W-1:0] dyn_da;
      logic                call_mark;
   } cost_entry_type;

endpackage

// File: rtl/two_budget_gas_meter_top.sv
// A charge word passes from acceptance through cost read, multiply and update; every
// other operation skips the multiply and goes through decode and update.
// The single execution unit finishes one word before it pops the next, and it holds a
// finished word in the update state while the result register is still full.
// Reset is synchronous and active high; it empties both queues, zeroes the budgets, the
// last row and all use counters at once. The cost store holds no reset value.
module two_budget_gas_meter_top
   import tbgm_pkg::*;
#(
   parameter int OPCODE_SLOTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         req_full,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   // The front end decodes each request word into a command and checks whether its
   // opcode falls inside the cost store. Commands wait in a two-entry queue so that new
   // words keep flowing in while the back end is busy with a multiply or stalled on a
   // full result register.
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    rsp_valid;

   tbgm_front #(
      .OPCODE_SLOTS(OPCODE_SLOTS)
   ) u_front (
      .req_push(req_push),
      .req_word(req_word),
      .req_full(req_full),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   tbgm_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .head_cmd(head_cmd),
      .empty   (q_empty)
   );

   // The back end owns the cost store, the use counters and the budgets. It holds the
   // finished result in its own output register, so the next command can start while a
   // result is still waiting to be popped.
   tbgm_back #(
      .OPCODE_SLOTS(OPCODE_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_cmd    (head_cmd),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word)
   );

   assign rsp_empty = !rsp_valid;

endmodule

// File: rtl/tbgm_front.sv
module tbgm_front
   import tbgm_pkg::*;
#(
   parameter int OPCODE_SLOTS = 256
) (
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         req_full,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   localparam logic [OPCODE_W:0] SLOT_LIMIT = (OPCODE_W+1)'(OPCODE_SLOTS);

   kind_type kind;

   always_comb begin
      case (req_word.operation)
         OPC_LOAD:   kind = KIND_LOAD;
         OPC_START:  kind = KIND_START;
         OPC_ENTER:  kind = KIND_ENTER;
         OPC_CHARGE: kind = KIND_CHARGE;
         OPC_RETURN: kind = KIND_RETURN;
         OPC_HALT:   kind = KIND_HALT;
         default:    kind = KIND_NOP;
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      q_cmd.kind        = kind;
      q_cmd.in_range    = ({1'b0, req_word.opcode} < SLOT_LIMIT);
      q_cmd.opcode      = req_word.opcode;
      q_cmd.mult        = req_word.dyn_multiplier;
      q_cmd.amt_l2      = req_word.l2_amount;
      q_cmd.amt_da      = req_word.da_amount;
      q_cmd.ext_l2      = req_word.l2_extra;
      q_cmd.ext_da      = req_word.da_extra;
      q_cmd.exceptional = req_word.exceptional;
      q_cmd.call_mark   = req_word.call_mark;
   end

endmodule

// File: rtl/tbgm_cmd_queue.sv
module tbgm_cmd_queue
   import tbgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/tbgm_back.sv
module tbgm_back
   import tbgm_pkg::*;
#(
   parameter int OPCODE_SLOTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   localparam int                IDX_W      = $clog2(OPCODE_SLOTS);
   localparam logic [OPCODE_W:0] SLOT_LIMIT = (OPCODE_W+1)'(OPCODE_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;

   cost_entry_type      cost_mem [OPCODE_SLOTS];
   cost_entry_type      cost_rd_ff;
   cost_entry_type      cost_eff;
   logic [AMOUNT_W-1:0] count_mem [OPCODE_SLOTS];
   logic [OPCODE_SLOTS-1:0] count_valid_ff;
   logic [AMOUNT_W-1:0] count_rd_ff;
   logic                count_rd_valid_ff;
   logic [AMOUNT_W-1:0] count_cur;

   logic [AMOUNT_W-1:0] prod_l2_ff, prod_da_ff;

   logic [AMOUNT_W-1:0] work_l2_ff, work_l2_in, work_da_ff, work_da_in;
   logic [AMOUNT_W-1:0] start_l2_ff, start_l2_in, start_da_ff, start_da_in;
   logic [AMOUNT_W-1:0] last_l2_ff, last_l2_in, last_da_ff, last_da_in;
   logic                row_exists_ff, row_exists_in;
   logic                last_tag_ff, last_tag_in;
   logic                pending_ff, pending_in;
   logic [OPCODE_W-1:0] last_op_ff, last_op_in;
   logic [AMOUNT_W-1:0] last_count_ff, last_count_in;
   logic                oog;

   logic                exec_fire;
   logic                cost_we;
   logic                cnt_we;
   logic [IDX_W-1:0]    cnt_waddr;
   logic [AMOUNT_W-1:0] cnt_wdata;
   logic [AMOUNT_W-1:0] cost_l2, cost_da, used_l2, used_da;
   logic                last_in_range;

   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_valid_ff, rsp_valid_in;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_pop);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign cost_eff      = cmd_ff.in_range ? cost_rd_ff : '0;
   assign count_cur     = count_rd_valid_ff ? count_rd_ff : '0;
   assign last_in_range = ({1'b0, last_op_ff} < SLOT_LIMIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_cmd.kind == KIND_CHARGE) ? ST_MUL : ST_EXEC;
            end
         end
         ST_MUL: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      work_l2_in    = work_l2_ff;
      work_da_in    = work_da_ff;
      start_l2_in   = start_l2_ff;
      start_da_in   = start_da_ff;
      last_l2_in    = last_l2_ff;
      last_da_in    = last_da_ff;
      row_exists_in = row_exists_ff;
      last_tag_in   = last_tag_ff;
      pending_in    = pending_ff;
      last_op_in    = last_op_ff;
      last_count_in = last_count_ff;
      oog           = 1'b0;
      cost_we       = 1'b0;
      cnt_we        = 1'b0;
      cnt_waddr     = cmd_ff.opcode[IDX_W-1:0];
      cnt_wdata     = count_cur + 32'd1;
      cost_l2       = cost_eff.base_l2 + prod_l2_ff
                    + (cost_eff.call_mark ? cmd_ff.amt_l2 : '0);
      cost_da       = cost_eff.base_da + prod_da_ff
                    + (cost_eff.call_mark ? cmd_ff.amt_da : '0);
      used_l2       = cmd_ff.exceptional ? cmd_ff.ext_l2 : cmd_ff.ext_l2 - work_l2_ff;
      used_da       = cmd_ff.exceptional ? cmd_ff.ext_da : cmd_ff.ext_da - work_da_ff;

      case (cmd_ff.kind)
         KIND_LOAD: begin
            cost_we = cmd_ff.in_range;
         end
         KIND_START: begin
            start_l2_in = cmd_ff.amt_l2;
            start_da_in = cmd_ff.amt_da;
            work_l2_in  = cmd_ff.amt_l2;
            work_da_in  = cmd_ff.amt_da;
         end
         KIND_ENTER: begin
            work_l2_in = cmd_ff.amt_l2;
            work_da_in = cmd_ff.amt_da;
            pending_in = 1'b1;
         end
         KIND_CHARGE: begin
            if (cost_l2 > work_l2_ff) begin
               work_l2_in = '0;
               work_da_in = '0;
               oog        = 1'b1;
            end else begin
               work_l2_in = work_l2_ff - cost_l2;
               work_da_in = work_da_ff - cost_da;
            end
            row_exists_in = 1'b1;
            last_l2_in    = work_l2_in;
            last_da_in    = work_da_in;
            last_op_in    = cmd_ff.opcode;
            last_tag_in   = pending_ff;
            pending_in    = 1'b0;
            cnt_we        = !pending_ff && cmd_ff.in_range;
            if (!cmd_ff.in_range) begin
               last_count_in = '0;
            end else if (pending_ff) begin
               last_count_in = count_cur;
            end else begin
               last_count_in = cnt_wdata;
            end
         end
         KIND_RETURN, KIND_HALT: begin
            if (cmd_ff.kind == KIND_RETURN) begin
               work_l2_in = cmd_ff.amt_l2 - used_l2;
               work_da_in = cmd_ff.amt_da - used_da;
            end else begin
               work_l2_in = '0;
               work_da_in = '0;
            end
            pending_in = 1'b0;
            // A halt or return rewrites the last row and takes back its count.
            if (row_exists_ff) begin
               last_l2_in  = work_l2_in;
               last_da_in  = work_da_in;
               last_tag_in = 1'b1;
               if (last_in_range) begin
                  cnt_we        = 1'b1;
                  cnt_waddr     = last_op_ff[IDX_W-1:0];
                  cnt_wdata     = last_count_ff - 32'd1;
                  last_count_in = cnt_wdata;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_word_in.gas_exhausted    = oog;
      rsp_word_in.l2_left          = work_l2_in;
      rsp_word_in.da_left          = work_da_in;
      rsp_word_in.reported_l2_left = row_exists_in ? last_l2_in : start_l2_in;
      rsp_word_in.reported_da_left = row_exists_in ? last_da_in : start_da_in;
      rsp_word_in.row_tag          = row_exists_in && last_tag_in;
      rsp_word_in.row_opcode       = row_exists_in ? last_op_in : '0;
      rsp_word_in.opcode_use_total = last_count_in;
      rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_valid_ff <= '0;
         work_l2_ff     <= '0;
         work_da_ff     <= '0;
         start_l2_ff    <= '0;
         start_da_ff    <= '0;
         last_l2_ff     <= '0;
         last_da_ff     <= '0;
         row_exists_ff  <= 1'b0;
         last_tag_ff    <= 1'b0;
         pending_ff     <= 1'b0;
         last_op_ff     <= '0;
         last_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire && cnt_we) begin
            count_valid_ff[cnt_waddr] <= 1'b1;
         end
         if (exec_fire) begin
            work_l2_ff    <= work_l2_in;
            work_da_ff    <= work_da_in;
            start_l2_ff   <= start_l2_in;
            start_da_ff   <= start_da_in;
            last_l2_ff    <= last_l2_in;
            last_da_ff    <= last_da_in;
            row_exists_ff <= row_exists_in;
            last_tag_ff   <= last_tag_in;
            pending_ff    <= pending_in;
            last_op_ff    <= last_op_in;
            last_count_ff <= last_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff            <= q_cmd;
         cost_rd_ff        <= cost_mem[q_cmd.opcode[IDX_W-1:0]];
         count_rd_ff       <= count_mem[q_cmd.opcode[IDX_W-1:0]];
         count_rd_valid_ff <= count_valid_ff[q_cmd.opcode[IDX_W-1:0]];
      end
      if (state_ff == ST_MUL) begin
         prod_l2_ff <= cmd_ff.mult * cost_eff.dyn_l2;
         prod_da_ff <= cmd_ff.mult * cost_eff.dyn_da;
      end
      if (exec_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && cost_we) begin
         cost_mem[cmd_ff.opcode[IDX_W-1:0]] <= '{
            base_l2:   cmd_ff.amt_l2,
            base_da:   cmd_ff.amt_da,
            dyn_l2:    cmd_ff.ext_l2,
            dyn_da:    cmd_ff.ext_da,
            call_mark: cmd_ff.call_mark
         };
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
   end

endmodule

// File: rtl/tbgm_checker.sv
module tbgm_checker
   import tbgm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_push,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);

   // Both queues come out of reset empty.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A result that is not taken stays on the ports unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting result changed");

   // Running out of gas drains both budgets and the row that records it.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.gas_exhausted |->
         rsp_word.l2_left == '0 && rsp_word.da_left == '0
         && rsp_word.reported_l2_left == '0 && rsp_word.reported_da_left == '0)
      else $error("out of gas with budget left");

   // The input side only fills up right after it has taken a word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full))
      else $error("full raised without an accepted word");

endmodule

bind two_budget_gas_meter_top tbgm_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_push (req_push),
   .req_full (req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_word (rsp_word)
);

// File: test/tb_two_budget_gas_meter_top.sv
module tb_two_budget_gas_meter_top;
   import tbgm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The package names the six live operation codes; the two spare codes are named
   // here so that the stimulus never spells them as bare numbers.
   localparam logic [2:0] OPC_SPARE6 = 3'd6;
   localparam logic [2:0] OPC_SPARE7 = 3'd7;

   localparam int RANDOM_WORDS  = 1600;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLDOFF_AT    = 500;
   localparam int HOLDOFF_LEN   = 400;
   localparam int CALM_FIRST    = 900;
   localparam int CALM_LAST     = 1100;
   localparam int SHOWN_MISSES  = 10;

   logic         clock;
   logic         reset;
   logic         req_push;
   req_word_type req_word;
   logic         req_full;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_word_type rsp_word;

   two_budget_gas_meter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // Free-running 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------------
   // Meter shadow. This is the testbench's own copy of everything the block keeps:
   // both working budgets, the start budgets, the last charged row, the per-opcode
   // use counters and the cost store. It is advanced once per accepted word.
   // ------------------------------------------------------------------------------
   logic [31:0]    m_work_l2, m_work_da, m_start_l2, m_start_da;
   logic [31:0]    m_row_l2, m_row_da;
   logic           m_row_valid, m_row_tag, m_nested_first;
   logic [7:0]     m_row_op;
   logic [31:0]    m_uses [256];
   cost_entry_type m_costs [256];

   // Bookkeeping for stimulus: charging an entry that was never loaded is not
   // allowed, so charges only pick opcodes from this list.
   bit             cost_loaded [256];
   logic [7:0]     loaded_opcodes [$];
   int             nest_countdown;

   // What the block must still report, oldest first.
   rsp_word_type   balance_reports_due [$];
   rsp_word_type   oldest_report;

   int             words_in, words_out, errors;
   int             starved_charges, nested_entries, row_rewrites;
   int             cycle_count;
   bit             calm_stretch;
   bit             holdoff_done;

   // A return or a halt turns the last charged row into a halt row and takes back
   // the use count that the row added. With no row yet, only the pending flag goes.
   function automatic void close_last_row();
      m_nested_first = 1'b0;
      if (m_row_valid) begin
         m_row_l2  = m_work_l2;
         m_row_da  = m_work_da;
         m_row_tag = 1'b1;
         m_uses[m_row_op] = m_uses[m_row_op] - 32'd1;
      end
   endfunction

   function automatic rsp_word_type advance_meter(req_word_type w);
      rsp_word_type   r;
      cost_entry_type c;
      logic [31:0]    cost_l2, cost_da, used_l2, used_da;
      logic           oog;
      r   = '0;
      oog = 1'b0;
      case (w.operation)
         OPC_LOAD: begin
            c.base_l2   = w.l2_amount;
            c.base_da   = w.da_amount;
            c.dyn_l2    = w.l2_extra;
            c.dyn_da    = w.da_extra;
            c.call_mark = w.call_mark;
            m_costs[w.opcode] = c;
         end
         OPC_START: begin
            m_start_l2 = w.l2_amount;
            m_work_l2  = w.l2_amount;
            m_start_da = w.da_amount;
            m_work_da  = w.da_amount;
         end
         OPC_ENTER: begin
            m_work_l2      = w.l2_amount;
            m_work_da      = w.da_amount;
            m_nested_first = 1'b1;
         end
         OPC_CHARGE: begin
            c = m_costs[w.opcode];
            // All products and sums wrap at 32 bits.
            cost_l2 = c.base_l2 + w.dyn_multiplier * c.dyn_l2
                      + (c.call_mark ? w.l2_amount : 32'd0);
            cost_da = c.base_da + w.dyn_multiplier * c.dyn_da
                      + (c.call_mark ? w.da_amount : 32'd0);
            if (cost_l2 > m_work_l2) begin
               m_work_l2 = '0;
               m_work_da = '0;
               oog       = 1'b1;
            end else begin
               m_work_l2 = m_work_l2 - cost_l2;
               m_work_da = m_work_da - cost_da;
            end
            m_row_valid = 1'b1;
            m_row_l2    = m_work_l2;
            m_row_da    = m_work_da;
            m_row_op    = w.opcode;
            m_row_tag   = m_nested_first;
            // The first row inside a nested call is tagged but not counted.
            if (m_nested_first)
               m_nested_first = 1'b0;
            else
               m_uses[w.opcode] = m_uses[w.opcode] + 32'd1;
         end
         OPC_RETURN: begin
            used_l2   = w.exceptional ? w.l2_extra : w.l2_extra - m_work_l2;
            used_da   = w.exceptional ? w.da_extra : w.da_extra - m_work_da;
            m_work_l2 = w.l2_amount - used_l2;
            m_work_da = w.da_amount - used_da;
            close_last_row();
         end
         OPC_HALT: begin
            m_work_l2 = '0;
            m_work_da = '0;
            close_last_row();
         end
         default: begin
            // Spare codes leave the meter alone and just report it.
         end
      endcase
      r.gas_exhausted    = oog;
      r.l2_left          = m_work_l2;
      r.da_left          = m_work_da;
      r.reported_l2_left = m_row_valid ? m_row_l2 : m_start_l2;
      r.reported_da_left = m_row_valid ? m_row_da : m_start_da;
      r.row_tag          = m_row_valid & m_row_tag;
      r.row_opcode       = m_row_valid ? m_row_op : 8'd0;
      r.opcode_use_total = m_row_valid ? m_uses[m_row_op] : 32'd0;
      return r;
   endfunction

   // ------------------------------------------------------------------------------
   // Word builders for the opening table.
   // ------------------------------------------------------------------------------
   function automatic req_word_type mk_req(logic [2:0] op, logic [7:0] opc,
                                           logic [31:0] mult, logic [31:0] l2,
                                           logic [31:0] da, logic [31:0] l2x,
                                           logic [31:0] dax, logic exc, logic mark);
      req_word_type w;
      w.operation      = op;
      w.opcode         = opc;
      w.dyn_multiplier = mult;
      w.l2_amount      = l2;
      w.da_amount      = da;
      w.l2_extra       = l2x;
      w.da_extra       = dax;
      w.exceptional    = exc;
      w.call_mark      = mark;
      return w;
   endfunction

   function automatic rsp_word_type mk_rsp(logic oog, logic [31:0] l2, logic [31:0] da,
                                           logic [31:0] rl2, logic [31:0] rda, logic tag,
                                           logic [7:0] opc, logic [31:0] uses);
      rsp_word_type r;
      r.gas_exhausted    = oog;
      r.l2_left          = l2;
      r.da_left          = da;
      r.reported_l2_left = rl2;
      r.reported_da_left = rda;
      r.row_tag          = tag;
      r.row_opcode       = opc;
      r.opcode_use_total = uses;
      return r;
   endfunction

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } plan_row_type;

   plan_row_type opening_plan [$];

   task automatic plan_row(input req_word_type w, input bit typed = 1'b0,
                           input rsp_word_type want = '0);
      plan_row_type p;
      p.w     = w;
      p.typed = typed;
      p.want  = want;
      opening_plan.insert(opening_plan.size(), p);
   endtask

   // Mostly modest amounts so that budgets last through many charges; now and then
   // a full 32-bit value so that every bit toggles and the wrap paths get hit.
   function automatic logic [31:0] amount(int unsigned hi);
      if ($urandom_range(99) < 20)
         return $urandom;
      return $urandom_range(hi);
   endfunction

   // ------------------------------------------------------------------------------
   // Random stimulus. Most words are charges against loaded opcodes. An enter is
   // followed by a short run of charges and then a return, so the nested-call path
   // (tagged first row, uncounted charge, row rewrite, counter take-back) is walked
   // over and over with random content. A small share of words is plain noise,
   // including the spare operation codes.
   // ------------------------------------------------------------------------------
   function automatic req_word_type next_random_word();
      req_word_type w;
      int           roll;
      w.operation      = OPC_CHARGE;
      w.opcode         = 8'($urandom);
      w.dyn_multiplier = $urandom;
      w.l2_amount      = $urandom;
      w.da_amount      = $urandom;
      w.l2_extra       = $urandom;
      w.da_extra       = $urandom;
      w.exceptional    = 1'($urandom);
      w.call_mark      = 1'($urandom);
      roll = $urandom_range(99);
      if (nest_countdown == 1) begin
         nest_countdown = 0;
         w.operation    = OPC_RETURN;
         w.l2_amount    = amount(2000000);
         w.da_amount    = amount(2000000);
         w.l2_extra     = amount(200000);
         w.da_extra     = amount(200000);
         return w;
      end
      if (nest_countdown > 1) begin
         nest_countdown--;
         roll = 99;
      end
      if (roll < 8) begin
         w.operation = OPC_LOAD;
         w.l2_amount = amount(60);
         w.da_amount = amount(60);
         w.l2_extra  = amount(10);
         w.da_extra  = amount(10);
      end else if (roll < 12) begin
         w.operation = OPC_START;
         w.l2_amount = amount(2000000);
         w.da_amount = amount(2000000);
      end else if (roll < 18) begin
         w.operation    = OPC_ENTER;
         w.l2_amount    = amount(200000);
         w.da_amount    = amount(200000);
         nest_countdown = $urandom_range(2, 7);
      end else if (roll < 22) begin
         w.operation = OPC_RETURN;
         w.l2_amount = amount(2000000);
         w.da_amount = amount(2000000);
      end else if (roll < 25) begin
         w.operation = OPC_HALT;
      end else if (roll < 29) begin
         w.operation = 3'($urandom_range(7));
         if (w.operation == OPC_CHARGE)
            w.opcode = loaded_opcodes[$urandom_range(loaded_opcodes.size() - 1)];
      end else begin
         w.opcode         = loaded_opcodes[$urandom_range(loaded_opcodes.size() - 1)];
         w.dyn_multiplier = amount(20);
         w.l2_amount      = amount(300);
         w.da_amount      = amount(300);
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------------
   // Request side. Entered at a falling edge; drives one word and holds it until
   // the block takes it (push high and full low at a rising edge). The meter shadow
   // is advanced at that same edge, so the expectation queue is always in step with
   // what the block has accepted. Typed expectations from the opening table replace
   // the shadow's answer for that word only; the shadow still advances.
   // ------------------------------------------------------------------------------
   task automatic offer(input req_word_type w, input bit typed, input rsp_word_type want);
      rsp_word_type guess;
      if (!calm_stretch && $urandom_range(99) < 14) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      guess = advance_meter(w);
      if (typed)
         guess = want;
      balance_reports_due.insert(balance_reports_due.size(), guess);
      words_in++;
      if (w.operation == OPC_LOAD && !cost_loaded[w.opcode]) begin
         cost_loaded[w.opcode] = 1'b1;
         loaded_opcodes.insert(loaded_opcodes.size(), w.opcode);
      end
      if (w.operation == OPC_ENTER)
         nested_entries++;
      if (w.operation == OPC_RETURN || w.operation == OPC_HALT)
         row_rewrites++;
      @(negedge clock);
   endtask

   initial begin
      reset    = 1'b1;
      req_push = 1'b0;
      req_word = '0;
      calm_stretch   = 1'b0;
      nest_countdown = 0;
      m_work_l2 = '0;  m_work_da = '0;  m_start_l2 = '0;  m_start_da = '0;
      m_row_l2  = '0;  m_row_da  = '0;  m_row_op   = '0;
      m_row_valid = 1'b0;  m_row_tag = 1'b0;  m_nested_first = 1'b0;
      foreach (m_uses[i]) begin
         m_uses[i]      = '0;
         m_costs[i]     = '0;
         cost_loaded[i] = 1'b0;
      end

      // Opening table. Rows with a typed expectation are the ones whose answer is
      // obvious: right after reset, the spare codes, a halt or return with no row,
      // a fresh start, the first load and a simple charge. The rest go through the shadow.
      // Spare codes straight after reset, with all fields low and then all high.
      plan_row(mk_req(OPC_SPARE6, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0), 1'b1, '0);
      plan_row(mk_req(OPC_SPARE7, 8'hFF, '1, '1, '1, '1, '1, 1'b1, 1'b1), 1'b1, '0);
      // Halt and returns before any row exists: budgets move, nothing else does.
      plan_row(mk_req(OPC_HALT, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0), 1'b1, '0);
      plan_row(mk_req(OPC_RETURN, 8'h00, '0, '1, '1, '0, '0, 1'b1, 1'b0), 1'b1,
               mk_rsp(1'b0, '1, '1, '0, '0, 1'b0, 8'h00, '0));
      plan_row(mk_req(OPC_RETURN, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      // A start reports its budgets as the start budgets while no row exists.
      plan_row(mk_req(OPC_START, 8'h00, '0, 32'd1000, 32'd500, '0, '0, 1'b0, 1'b0), 1'b1,
               mk_rsp(1'b0, 32'd1000, 32'd500, 32'd1000, 32'd500, 1'b0, 8'h00, '0));
      plan_row(mk_req(OPC_LOAD, 8'h00, '0, 32'd10, 32'd20, 32'd1, 32'd2, 1'b0, 1'b0), 1'b1,
               mk_rsp(1'b0, 32'd1000, 32'd500, 32'd1000, 32'd500, 1'b0, 8'h00, '0));
      plan_row(mk_req(OPC_LOAD, 8'hFF, '1, '1, '1, '1, '1, 1'b1, 1'b1));
      plan_row(mk_req(OPC_LOAD, 8'h80, '0, 32'd5, 32'd7, '0, '0, 1'b0, 1'b1));
      plan_row(mk_req(OPC_LOAD, 8'h7F, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      // Plain charge: 10 + 3*1 and 20 + 3*2 come off the budgets.
      plan_row(mk_req(OPC_CHARGE, 8'h00, 32'd3, '1, '1, '0, '0, 1'b0, 1'b0), 1'b1,
               mk_rsp(1'b0, 32'd987, 32'd474, 32'd987, 32'd474, 1'b0, 8'h00, 32'd1));
      // Zero-cost entry with the largest multiplier, then an all-ones call-type
      // entry that runs out of gas.
      plan_row(mk_req(OPC_CHARGE, 8'h7F, '1, '0, '0, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'hFF, '1, '1, '1, '0, '0, 1'b0, 1'b0));
      // Cost exactly equal to the L2 budget is allowed, and DA wraps below zero.
      plan_row(mk_req(OPC_START, 8'h00, '0, 32'd10, 32'd5, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      // Nested call: the first row is tagged and uncounted, the second is counted,
      // and the return rewrites the row and takes its count back.
      plan_row(mk_req(OPC_START, 8'h00, '0, '1, '1, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_ENTER, 8'h00, '0, 32'd300, 32'd40, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'h80, 32'd9, 32'd100, 32'd10, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'h80, '1, 32'd100, 32'd10, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_RETURN, 8'h00, '0, 32'd5000, 32'd6000, 32'd300, 32'd40,
                      1'b0, 1'b0));
      // Exceptional return, then repeated halts drive a use counter below zero.
      plan_row(mk_req(OPC_ENTER, 8'h00, '0, 32'd50, 32'd50, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'h00, 32'd1, '0, '0, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_RETURN, 8'h00, '0, 32'd900, 32'd900, 32'd50, 32'd50,
                      1'b1, 1'b0));
      plan_row(mk_req(OPC_HALT, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_HALT, 8'h00, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      // L2 cost one above the budget.
      plan_row(mk_req(OPC_START, 8'h00, '0, 32'd10, '0, '0, '0, 1'b0, 1'b0));
      plan_row(mk_req(OPC_CHARGE, 8'h00, 32'd1, '0, '0, '0, '0, 1'b0, 1'b0));

      // Synchronous reset first, released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i])
         offer(opening_plan[i].w, opening_plan[i].typed, opening_plan[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // One long stretch where neither side idles.
         calm_stretch = (n >= CALM_FIRST && n < CALM_LAST);
         offer(next_random_word(), 1'b0, '0);
      end
      req_push     <= 1'b0;
      calm_stretch = 1'b0;

      // Drain: wait for every expected word, then go on watching for strays before the summary.
      while (balance_reports_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d checked; %0d nested calls, %0d row rewrites,",
               words_in, words_out, nested_entries, row_rewrites);
      $display("%0d out-of-gas charges, %0d opcodes loaded, %0d mismatches",
               starved_charges, loaded_opcodes.size(), errors);
      if (errors == 0)
         $display("tb_two_budget_gas_meter_top: done, clean");
      else
         $display("tb_two_budget_gas_meter_top: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------------
   // Result side. Pop is decided at the falling edge. Once, after a few hundred
   // results, the receiver stops taking words for a long stretch while the sender
   // keeps pushing, so the block fills and raises full.
   // ------------------------------------------------------------------------------
   initial begin
      rsp_pop      = 1'b0;
      holdoff_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && words_out >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLDOFF_LEN) @(negedge clock);
         end
         rsp_pop <= calm_stretch || ($urandom_range(99) >= 14);
      end
   end

   task automatic flag_miss(input string what, input logic [31:0] want,
                            input logic [31:0] got);
      errors++;
      if (errors <= SHOWN_MISSES)
         $display("result word %0d: %s expected %h, got %h", words_out, what, want, got);
   endtask

   // Every accepted result word is checked field by field against the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (balance_reports_due.size() == 0) begin
            errors++;
            if (errors <= SHOWN_MISSES)
               $display("result word %0d arrived with nothing expected", words_out);
         end else begin
            oldest_report = balance_reports_due.pop_front();
            if (rsp_word.gas_exhausted)
               starved_charges++;
            if (rsp_word.gas_exhausted !== oldest_report.gas_exhausted)
               flag_miss("gas_exhausted", 32'(oldest_report.gas_exhausted),
                         32'(rsp_word.gas_exhausted));
            if (rsp_word.l2_left !== oldest_report.l2_left)
               flag_miss("l2_left", oldest_report.l2_left, rsp_word.l2_left);
            if (rsp_word.da_left !== oldest_report.da_left)
               flag_miss("da_left", oldest_report.da_left, rsp_word.da_left);
            if (rsp_word.reported_l2_left !== oldest_report.reported_l2_left)
               flag_miss("reported_l2_left", oldest_report.reported_l2_left,
                         rsp_word.reported_l2_left);
            if (rsp_word.reported_da_left !== oldest_report.reported_da_left)
               flag_miss("reported_da_left", oldest_report.reported_da_left,
                         rsp_word.reported_da_left);
            if (rsp_word.row_tag !== oldest_report.row_tag)
               flag_miss("row_tag", 32'(oldest_report.row_tag), 32'(rsp_word.row_tag));
            if (rsp_word.row_opcode !== oldest_report.row_opcode)
               flag_miss("row_opcode", 32'(oldest_report.row_opcode),
                         32'(rsp_word.row_opcode));
            if (rsp_word.opcode_use_total !== oldest_report.opcode_use_total)
               flag_miss("opcode_use_total", oldest_report.opcode_use_total,
                         rsp_word.opcode_use_total);
         end
         words_out++;
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_two_budget_gas_meter_top: done, errors");
      $finish;
   end

endmodule
